// ----- hw/rtl/best_fit_allocator_top_assert.svh -----
// ----------------------------------------------------------------------------
// best_fit_allocator_top_assert.svh
// assertion macros used by the allocator checker
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define BFA_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFA_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// shared constants, status codes and control types of the allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

	localparam int unsigned MAX_ALLOCS_DEF = 16;
	localparam int unsigned MAX_HOLES_DEF  = 17;
	localparam int unsigned MEM_UNITS_DEF  = 1000;

	localparam int unsigned UW     = 10;
	localparam int unsigned IDW    = 8;
	localparam int unsigned STW    = 3;
	localparam int unsigned HCNT_W = 5;
	localparam int unsigned AW     = 3;
	localparam int unsigned DW     = 32;

	localparam logic REG_TOTAL_SIZE = 1'b0;

	localparam logic [STW-1:0] ST_ALLOC    = 3'd0;
	localparam logic [STW-1:0] ST_FREED    = 3'd1;
	localparam logic [STW-1:0] ST_NO_TOTAL = 3'd2;
	localparam logic [STW-1:0] ST_NO_FIT   = 3'd3;
	localparam logic [STW-1:0] ST_UNKNOWN  = 3'd4;
	localparam logic [STW-1:0] ST_FULL     = 3'd5;

	typedef struct packed {
		logic           load;
		logic           find_step;
		logic           take_free;
		logic           best_step;
		logic           alloc_commit;
		logic           build_step;
		logic           div_init;
		logic           div_step;
		logic           status_we;
		logic [STW-1:0] status_code;
	} bfa_cmd_t;

	typedef struct packed {
		logic is_free;
		logic short_total;
		logic find_end;
		logic find_hit;
		logic best_end;
		logic best_none;
		logic table_full;
		logic build_done;
		logic div_end;
	} bfa_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfa_ctrl
// request sequencer: dispatch, scans, hole list rebuild, divide, result
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire bfa_pkg::bfa_stat_t stat,
	output bfa_pkg::bfa_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_FIND  = 4'd2;
	localparam logic [3:0] S_BEST  = 4'd3;
	localparam logic [3:0] S_PICK  = 4'd4;
	localparam logic [3:0] S_BUILD = 4'd5;
	localparam logic [3:0] S_DIVI  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.is_free) begin
					state_d = S_FIND;
				end else if (stat.short_total) begin
					cmd.status_we   = 1'b1;
					cmd.status_code = bfa_pkg::ST_NO_TOTAL;
					state_d         = S_DIVI;
				end else begin
					state_d = S_BEST;
				end
			end
			S_FIND: begin
				if (stat.find_end) begin
					cmd.status_we   = 1'b1;
					cmd.status_code = bfa_pkg::ST_UNKNOWN;
					state_d         = S_DIVI;
				end else if (stat.find_hit) begin
					cmd.take_free   = 1'b1;
					cmd.status_we   = 1'b1;
					cmd.status_code = bfa_pkg::ST_FREED;
					state_d         = S_BUILD;
				end else begin
					cmd.find_step = 1'b1;
				end
			end
			S_BEST: begin
				if (stat.best_end) begin
					state_d = S_PICK;
				end else begin
					cmd.best_step = 1'b1;
				end
			end
			S_PICK: begin
				cmd.status_we = 1'b1;
				if (stat.best_none) begin
					cmd.status_code = bfa_pkg::ST_NO_FIT;
					state_d         = S_DIVI;
				end else if (stat.table_full) begin
					cmd.status_code = bfa_pkg::ST_FULL;
					state_d         = S_DIVI;
				end else begin
					cmd.status_code  = bfa_pkg::ST_ALLOC;
					cmd.alloc_commit = 1'b1;
					state_d          = S_BUILD;
				end
			end
			S_BUILD: begin
				cmd.build_step = 1'b1;
				if (stat.build_done) begin
					state_d = S_DIVI;
				end
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

`default_nettype wire

// ----- hw/rtl/bfa_dpath.sv -----
// ----------------------------------------------------------------------------
// bfa_dpath
// hole list banks, allocation table, scan counters and serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_dpath #(
	parameter int unsigned MAX_ALLOCS = bfa_pkg::MAX_ALLOCS_DEF,
	parameter int unsigned MAX_HOLES  = bfa_pkg::MAX_HOLES_DEF,
	parameter int unsigned MEM_UNITS  = bfa_pkg::MEM_UNITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bfa_pkg::bfa_cmd_t          cmd,
	input  wire logic                       cfg_we,
	input  wire logic [bfa_pkg::UW-1:0]     cfg_total,
	input  wire logic [bfa_pkg::IDW-1:0]    request_id,
	input  wire logic [bfa_pkg::UW-1:0]     request_size,
	output bfa_pkg::bfa_stat_t              stat,
	output logic [bfa_pkg::STW-1:0]         status,
	output logic [bfa_pkg::UW-1:0]          block_address,
	output logic [bfa_pkg::UW-1:0]          free_total,
	output logic [bfa_pkg::HCNT_W-1:0]      hole_count,
	output logic [bfa_pkg::UW-1:0]          average_hole,
	output logic [bfa_pkg::UW-1:0]          total_size
);

	localparam int unsigned UW  = bfa_pkg::UW;
	localparam int unsigned HIW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int unsigned HCW = $clog2(MAX_HOLES + 1);
	localparam int unsigned AIW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
	localparam int unsigned ACW = $clog2(MAX_ALLOCS + 1);
	localparam int unsigned DCW = $clog2(UW);

	logic [UW-1:0] hs_q [2][MAX_HOLES];
	logic [UW-1:0] he_q [2][MAX_HOLES];
	logic [bfa_pkg::IDW-1:0] aid_q [MAX_ALLOCS];
	logic [UW-1:0] astart_q [MAX_ALLOCS];
	logic [UW-1:0] asize_q [MAX_ALLOCS];

	logic [UW-1:0]  total_q;
	logic [UW-1:0]  free_q;
	logic [HCW-1:0] holes_q;
	logic [ACW-1:0] cnt_q;
	logic           bank_q;
	logic           fresh_q;

	logic [bfa_pkg::IDW-1:0] req_id_q;
	logic [UW-1:0]  req_size_q;
	logic           is_free_q;
	logic [ACW-1:0] aidx_q;
	logic [AIW-1:0] slot_q;
	logic [UW-1:0]  bs_q;
	logic [UW-1:0]  be_q;
	logic [UW-1:0]  asz_q;
	logic [HCW-1:0] hi_q;
	logic [HCW-1:0] k_q;
	logic [UW-1:0]  last_e_q;
	logic           placed_q;
	logic           found_q;
	logic [HCW-1:0] best_q;
	logic [UW-1:0]  best_len_q;
	logic [UW-1:0]  best_start_q;
	logic [bfa_pkg::STW-1:0] status_q;
	logic [UW-1:0]  addr_q;
	logic [UW-1:0]  dq_q;
	logic [HCW-1:0] rem_q;
	logic [DCW-1:0] dcnt_q;

	logic [HIW-1:0] hidx;
	logic [AIW-1:0] aidx;
	logic [UW-1:0]  rd_s;
	logic [UW-1:0]  rd_e;
	logic [UW-1:0]  len;
	logic           fit;
	logic           at_end;
	logic           ins;
	logic           build_done;
	logic [UW-1:0]  el_s;
	logic [UW-1:0]  el_e;
	logic           el_ok;
	logic           merge;
	logic           room;
	logic [HCW-1:0] km1;
	logic [HCW:0]   rem_sh;
	logic [HCW:0]   rem_diff;
	logic           rem_ge;

	assign hidx = hi_q[HIW-1:0];
	assign aidx = aidx_q[AIW-1:0];
	assign rd_s = (fresh_q && hi_q == '0) ? '0 : hs_q[bank_q][hidx];
	assign rd_e = (fresh_q && hi_q == '0) ? total_q : he_q[bank_q][hidx];
	assign len  = rd_e - rd_s;
	assign fit  = (rd_e >= rd_s) && (len >= req_size_q) && (!found_q || len < best_len_q);

	assign at_end     = (hi_q == holes_q);
	assign ins        = is_free_q && !placed_q && (at_end || rd_s > bs_q);
	assign build_done = at_end && !(is_free_q && !placed_q);
	assign el_s = ins ? bs_q :
		((!is_free_q && hi_q == best_q) ? rd_s + req_size_q : rd_s);
	assign el_e  = ins ? be_q : rd_e;
	assign el_ok = (el_e > el_s);
	assign merge = (k_q != '0) && (last_e_q == el_s);
	assign room  = (k_q < HCW'(MAX_HOLES));
	assign km1   = k_q - 1'b1;

	assign rem_sh   = {rem_q, dq_q[UW-1]};
	assign rem_diff = rem_sh - {1'b0, holes_q};
	assign rem_ge   = (rem_sh >= {1'b0, holes_q});

	assign stat.is_free     = is_free_q;
	assign stat.short_total = (free_q < req_size_q);
	assign stat.find_end    = (aidx_q == cnt_q);
	assign stat.find_hit    = (aid_q[aidx] == req_id_q);
	assign stat.best_end    = at_end;
	assign stat.best_none   = !found_q;
	assign stat.table_full  = (cnt_q == ACW'(MAX_ALLOCS));
	assign stat.build_done  = build_done;
	assign stat.div_end     = (dcnt_q == DCW'(UW - 1));

	// payload stores
	always_ff @(posedge clk) begin
		if (cmd.build_step && !build_done && el_ok) begin
			if (merge) begin
				he_q[~bank_q][km1[HIW-1:0]] <= el_e;
			end else if (room) begin
				hs_q[~bank_q][k_q[HIW-1:0]] <= el_s;
				he_q[~bank_q][k_q[HIW-1:0]] <= el_e;
			end
		end
		if (cmd.alloc_commit) begin
			aid_q[cnt_q[AIW-1:0]]    <= req_id_q;
			astart_q[cnt_q[AIW-1:0]] <= best_start_q;
			asize_q[cnt_q[AIW-1:0]]  <= req_size_q;
		end
		if (cmd.build_step && build_done && is_free_q) begin
			for (int i = 0; i < int'(MAX_ALLOCS) - 1; i++) begin
				if (AIW'(i) >= slot_q) begin
					aid_q[i]    <= aid_q[i+1];
					astart_q[i] <= astart_q[i+1];
					asize_q[i]  <= asize_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= UW'(MEM_UNITS);
			free_q       <= UW'(MEM_UNITS);
			holes_q      <= HCW'(1);
			cnt_q        <= '0;
			bank_q       <= 1'b0;
			fresh_q      <= 1'b1;
			req_id_q     <= '0;
			req_size_q   <= '0;
			is_free_q    <= 1'b0;
			aidx_q       <= '0;
			slot_q       <= '0;
			bs_q         <= '0;
			be_q         <= '0;
			asz_q        <= '0;
			hi_q         <= '0;
			k_q          <= '0;
			last_e_q     <= '0;
			placed_q     <= 1'b0;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			status_q     <= bfa_pkg::ST_ALLOC;
			addr_q       <= '0;
			dq_q         <= '0;
			rem_q        <= '0;
			dcnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_total;
				free_q  <= cfg_total;
				holes_q <= (cfg_total != '0) ? HCW'(1) : '0;
				cnt_q   <= '0;
				fresh_q <= 1'b1;
			end
			if (cmd.load) begin
				req_id_q   <= request_id;
				req_size_q <= request_size;
				is_free_q  <= (request_size == '0);
				aidx_q     <= '0;
				hi_q       <= '0;
				found_q    <= 1'b0;
				addr_q     <= '0;
			end
			if (cmd.find_step) begin
				aidx_q <= aidx_q + 1'b1;
			end
			if (cmd.take_free) begin
				slot_q   <= aidx;
				bs_q     <= astart_q[aidx];
				asz_q    <= asize_q[aidx];
				be_q     <= astart_q[aidx] + asize_q[aidx];
				addr_q   <= astart_q[aidx];
				hi_q     <= '0;
				k_q      <= '0;
				placed_q <= 1'b0;
			end
			if (cmd.best_step) begin
				hi_q <= hi_q + 1'b1;
				if (fit) begin
					found_q      <= 1'b1;
					best_q       <= hi_q;
					best_len_q   <= len;
					best_start_q <= rd_s;
				end
			end
			if (cmd.alloc_commit) begin
				addr_q   <= best_start_q;
				free_q   <= free_q - req_size_q;
				cnt_q    <= cnt_q + 1'b1;
				hi_q     <= '0;
				k_q      <= '0;
				placed_q <= 1'b0;
			end
			if (cmd.build_step) begin
				if (build_done) begin
					holes_q <= k_q;
					bank_q  <= ~bank_q;
					fresh_q <= 1'b0;
					if (is_free_q) begin
						free_q <= free_q + asz_q;
						cnt_q  <= cnt_q - 1'b1;
					end
				end else begin
					if (ins) begin
						placed_q <= 1'b1;
					end else begin
						hi_q <= hi_q + 1'b1;
					end
					if (el_ok && (merge || room)) begin
						last_e_q <= el_e;
						if (!merge) begin
							k_q <= k_q + 1'b1;
						end
					end
				end
			end
			if (cmd.status_we) begin
				status_q <= cmd.status_code;
			end
			if (cmd.div_init) begin
				dq_q   <= free_q;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			if (cmd.div_step) begin
				dq_q   <= {dq_q[UW-2:0], rem_ge};
				rem_q  <= rem_ge ? rem_diff[HCW-1:0] : rem_sh[HCW-1:0];
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	assign status        = status_q;
	assign block_address = addr_q;
	assign free_total    = free_q;
	assign hole_count    = bfa_pkg::HCNT_W'(holes_q);
	assign average_hole  = (holes_q == '0) ? '0 : dq_q;
	assign total_size    = total_q;

endmodule

`default_nettype wire

// ----- hw/rtl/best_fit_allocator_top.sv -----
// free: table search for the id, then, on a hit, the hole list rebuild
// allocate: unless free space is short, best-fit scan over the holes; if placed, the hole list rebuild
// every request ends in a 10-step serial divide for the average hole size
// next request taken in the cycle after done; none is taken while busy
// reset: one hole covering the whole memory, empty table, no clearing pass, results cannot stall
// ----------------------------------------------------------------------------
// best_fit_allocator_top
// best-fit contiguous allocator with sorted, merged hole list
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_allocator_top #(
	parameter int unsigned MAX_ALLOCS = bfa_pkg::MAX_ALLOCS_DEF,
	parameter int unsigned MAX_HOLES  = bfa_pkg::MAX_HOLES_DEF,
	parameter int unsigned MEM_UNITS  = bfa_pkg::MEM_UNITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bfa_pkg::AW-1:0]     paddr,
	input  wire logic [bfa_pkg::DW-1:0]     pwdata,
	output logic [bfa_pkg::DW-1:0]          prdata,
	output logic                            pready,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [bfa_pkg::IDW-1:0]    request_id,
	input  wire logic [bfa_pkg::UW-1:0]     request_size,
	output logic                            done,
	output logic [bfa_pkg::STW-1:0]         status,
	output logic [bfa_pkg::UW-1:0]          block_address,
	output logic [bfa_pkg::UW-1:0]          free_total,
	output logic [bfa_pkg::HCNT_W-1:0]      hole_count,
	output logic [bfa_pkg::UW-1:0]          average_hole
);

	bfa_pkg::bfa_cmd_t  cmd;
	bfa_pkg::bfa_stat_t stat;
	logic                   cfg_we;
	logic                   sel_total;
	logic [bfa_pkg::UW-1:0] total_size;

	assign pready    = 1'b1;
	assign sel_total = (paddr[2] == bfa_pkg::REG_TOTAL_SIZE) && (paddr[1:0] == 2'b00);
	assign cfg_we    = psel && penable && pwrite && sel_total;
	assign prdata    = sel_total ? {{(bfa_pkg::DW - bfa_pkg::UW){1'b0}}, total_size} : '0;

	bfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bfa_dpath #(
		.MAX_ALLOCS (MAX_ALLOCS),
		.MAX_HOLES  (MAX_HOLES),
		.MEM_UNITS  (MEM_UNITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_total     (pwdata[bfa_pkg::UW-1:0]),
		.request_id    (request_id),
		.request_size  (request_size),
		.stat          (stat),
		.status        (status),
		.block_address (block_address),
		.free_total    (free_total),
		.hole_count    (hole_count),
		.average_hole  (average_hole),
		.total_size    (total_size)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/bfa_checker.sv -----
// ----------------------------------------------------------------------------
// bfa_checker
// port-level checks of the request and result transaction sequence
// ----------------------------------------------------------------------------
`default_nettype none

`include "best_fit_allocator_top_assert.svh"

module bfa_checker (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    start,
	input wire logic                    busy,
	input wire logic                    done,
	input wire logic [bfa_pkg::STW-1:0] status
);

	`BFA_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy, "request not taken up")
	`BFA_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy, "result outside a transaction")
	`BFA_ASSERT_NXT(a_done_ends, clk, arst_n, done, !done && !busy, "result not a single pulse")
	`BFA_ASSERT_IMP(a_status_code, clk, arst_n, done, status <= bfa_pkg::ST_FULL, "bad status")

endmodule

bind best_fit_allocator_top bfa_checker u_bfa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status)
);

`default_nettype wire

// ----- dv/tb_best_fit_allocator_top.sv -----
// ----------------------------------------------------------------------------
// tb_best_fit_allocator_top
// checks the best-fit allocator against a predictor of its hole list and
// allocation table: directed table of requests, then random allocate and
// free traffic over several memory sizes, with random idle cycles
// ----------------------------------------------------------------------------
`default_nettype none

module tb_best_fit_allocator_top;

	localparam int NALLOC = 16;
	localparam int NHOLE = 17;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam int STW    = bfa_pkg::STW;
	localparam int UW     = bfa_pkg::UW;
	localparam int IDW    = bfa_pkg::IDW;
	localparam int HCNT_W = bfa_pkg::HCNT_W;
	localparam int AW     = bfa_pkg::AW;
	localparam int DW     = bfa_pkg::DW;

	typedef struct packed {
		logic [STW-1:0]    st;
		logic [UW-1:0]     addr;
		logic [UW-1:0]     ftot;
		logic [HCNT_W-1:0] hcnt;
		logic [UW-1:0]     avg;
	} alloc_result_t;

	typedef struct {
		logic [IDW-1:0] id;
		logic [UW-1:0]  size;
		bit             typed;
		alloc_result_t  res;
	} req_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [AW-1:0] paddr;
	logic [DW-1:0] pwdata, prdata;
	logic pready;
	logic start, busy, done;
	logic [IDW-1:0] request_id;
	logic [UW-1:0] request_size;
	logic [STW-1:0] status;
	logic [UW-1:0] block_address, free_total, average_hole;
	logic [HCNT_W-1:0] hole_count;

	best_fit_allocator_top DUT (.*);

	// predictor state
	int space_units, free_left, n_holes;
	int h_lo[NHOLE], h_hi[NHOLE];
	int a_id[NALLOC], a_lo[NALLOC], a_len[NALLOC];
	bit a_live[NALLOC];
	int t_lo[NHOLE+1], t_hi[NHOLE+1];

	alloc_result_t pending_results[$];
	req_row_t rows[$];
	int fails = 0;
	int idle_count = 0;
	bit no_gaps = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_memory(int sz);
		space_units = sz;
		for (int i = 0; i < NALLOC; i++) a_live[i] = 0;
		h_lo[0] = 0;
		h_hi[0] = sz;
		n_holes = (sz != 0) ? 1 : 0;
		free_left = sz;
	endfunction

	function automatic void rebuild_holes(int n);
		int k;
		k = 0;
		for (int i = 0; i < n; i++) begin
			if (t_hi[i] <= t_lo[i]) continue;
			if (k > 0 && h_hi[k-1] == t_lo[i]) begin
				h_hi[k-1] = t_hi[i];
				continue;
			end
			if (k < NHOLE) begin
				h_lo[k] = t_lo[i];
				h_hi[k] = t_hi[i];
				k++;
			end
		end
		n_holes = k;
	endfunction

	function automatic alloc_result_t predict_request(int id, int size);
		alloc_result_t r;
		int slot, n, best, best_len, blo, bhi;
		bit placed;
		r.addr = '0;
		if (size == 0) begin
			slot = NALLOC;
			for (int i = NALLOC - 1; i >= 0; i--)
				if (a_live[i] && a_id[i] == id) slot = i;
			if (slot == NALLOC) r.st = bfa_pkg::ST_UNKNOWN;
			else begin
				blo = a_lo[slot];
				bhi = (blo + a_len[slot]) & 'h3ff;
				n = 0;
				placed = 0;
				for (int i = 0; i < n_holes; i++) begin
					if (!placed && h_lo[i] > blo) begin
						t_lo[n] = blo; t_hi[n] = bhi; n++;
						placed = 1;
					end
					t_lo[n] = h_lo[i]; t_hi[n] = h_hi[i]; n++;
				end
				if (!placed) begin
					t_lo[n] = blo; t_hi[n] = bhi; n++;
				end
				rebuild_holes(n);
				free_left = (free_left + a_len[slot]) & 'h3ff;
				r.addr = UW'(blo);
				for (int i = slot; i + 1 < NALLOC; i++) begin
					a_id[i] = a_id[i+1]; a_lo[i] = a_lo[i+1];
					a_len[i] = a_len[i+1]; a_live[i] = a_live[i+1];
				end
				a_live[NALLOC-1] = 0;
				r.st = bfa_pkg::ST_FREED;
			end
		end else if (free_left < size) r.st = bfa_pkg::ST_NO_TOTAL;
		else begin
			best = NHOLE;
			best_len = 0;
			for (int i = 0; i < n_holes; i++)
				if (h_hi[i] >= h_lo[i] && h_hi[i] - h_lo[i] >= size &&
						(best == NHOLE || h_hi[i] - h_lo[i] < best_len)) begin
					best = i;
					best_len = h_hi[i] - h_lo[i];
				end
			slot = 0;
			while (slot < NALLOC && a_live[slot]) slot++;
			if (best == NHOLE) r.st = bfa_pkg::ST_NO_FIT;
			else if (slot >= NALLOC) r.st = bfa_pkg::ST_FULL;
			else begin
				a_id[slot] = id; a_lo[slot] = h_lo[best];
				a_len[slot] = size; a_live[slot] = 1;
				r.addr = UW'(h_lo[best]);
				h_lo[best] = (h_lo[best] + size) & 'h3ff;
				free_left = (free_left - size) & 'h3ff;
				for (int i = 0; i < n_holes; i++) begin
					t_lo[i] = h_lo[i]; t_hi[i] = h_hi[i];
				end
				rebuild_holes(n_holes);
				r.st = bfa_pkg::ST_ALLOC;
			end
		end
		r.ftot = UW'(free_left);
		r.hcnt = HCNT_W'(n_holes);
		r.avg = (n_holes != 0) ? UW'(free_left / n_holes) : '0;
		return r;
	endfunction

	function automatic void add_row(int id, int size, bit typed, alloc_result_t res);
		req_row_t row;
		row.id = IDW'(id);
		row.size = UW'(size);
		row.typed = typed;
		row.res = res;
		rows.insert(rows.size(), row);
	endfunction

	task automatic issue_request(int id, int size, bit typed, alloc_result_t tr);
		alloc_result_t r;
		start <= 1'b1;
		request_id <= IDW'(id);
		request_size <= UW'(size);
		do @(posedge clk); while (busy);
		r = predict_request(id, size);
		pending_results.insert(pending_results.size(), typed ? tr : r);
		if (!no_gaps && $urandom_range(0, 99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_total_size(int sz);
		drain_results();
		repeat (60) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= AW'(4 * bfa_pkg::REG_TOTAL_SIZE);
		pwdata <= DW'(sz);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		clear_memory(sz);
		@(posedge clk);
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 0;
		if (r < 88) return $urandom_range(1, (space_units / 4 > 1) ? space_units / 4 : 1);
		return $urandom_range(1, 1023);
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			alloc_result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction, status %0d", $time, status);
				fails++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$display("%0t: status exp %0d got %0d", $time, e.st, status);
					fails++;
				end
				if (block_address !== e.addr) begin
					$display("%0t: block_address exp %0d got %0d", $time, e.addr,
						block_address);
					fails++;
				end
				if (free_total !== e.ftot) begin
					$display("%0t: free_total exp %0d got %0d", $time, e.ftot, free_total);
					fails++;
				end
				if (hole_count !== e.hcnt) begin
					$display("%0t: hole_count exp %0d got %0d", $time, e.hcnt, hole_count);
					fails++;
				end
				if (average_hole !== e.avg) begin
					$display("%0t: average_hole exp %0d got %0d", $time, e.avg,
						average_hole);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable)) idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		req_row_t row;
		alloc_result_t none;
		int sizes[8];
		none = '0;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		start = 1'b0; request_id = '0; request_size = '0;
		clear_memory(bfa_pkg::MEM_UNITS_DEF);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(1, 0, 1, '{bfa_pkg::ST_UNKNOWN, 10'd0, 10'd1000, 5'd1, 10'd1000});
		add_row(0, 1023, 1, '{bfa_pkg::ST_NO_TOTAL, 10'd0, 10'd1000, 5'd1, 10'd1000});
		add_row(255, 1000, 1, '{bfa_pkg::ST_ALLOC, 10'd0, 10'd0, 5'd0, 10'd0});
		add_row(255, 0, 1, '{bfa_pkg::ST_FREED, 10'd0, 10'd1000, 5'd1, 10'd1000});
		for (int i = 0; i < 16; i++) add_row(7, 1, 0, none);
		add_row(7, 1, 1, '{bfa_pkg::ST_FULL, 10'd0, 10'd984, 5'd1, 10'd984});
		add_row(7, 0, 0, none);
		add_row(7, 0, 0, none);
		add_row(170, 682, 0, none);
		add_row(85, 341, 0, none);
		foreach (rows[i]) begin
			row = rows[i];
			issue_request(row.id, row.size, row.typed, row.res);
		end

		sizes = '{1023, 1, 40, 100, 513, 1000, 0, 0};
		sizes[7] = $urandom_range(1, 1023);
		foreach (sizes[p]) begin
			write_total_size(sizes[p]);
			no_gaps = (p == 4);
			for (int i = 0; i < 100; i++) begin
				if (i == 50) drain_results();
				issue_request(($urandom_range(0, 99) < 80) ? $urandom_range(0, 5)
					: $urandom_range(0, 255), pick_size(), 0, none);
			end
		end
		no_gaps = 0;

		drain_results();
		repeat (100) @(posedge clk);
		if (fails == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
